@@ rtl/kffc_pkg.sv @@
// Shared types, key and event codes for the keypad four-function calculator.
package kffc_pkg;

   // Default operand width and the fixed width of the result fields
   localparam int NUM_WIDTH_DEF = 32;
   localparam int OUT_WIDTH     = 32;

   // Key kinds carried on the request tuser
   localparam logic [2:0] KEY_DIGIT  = 3'd0;
   localparam logic [2:0] KEY_ADD    = 3'd1;
   localparam logic [2:0] KEY_SUB    = 3'd2;
   localparam logic [2:0] KEY_MUL    = 3'd3;
   localparam logic [2:0] KEY_DIV    = 3'd4;
   localparam logic [2:0] KEY_EQUALS = 3'd5;
   localparam logic [2:0] KEY_CLEAR  = 3'd6;

   // Result event codes carried on the response tuser
   typedef enum logic [2:0] {
      EV_IGNORED  = 3'd0,
      EV_FIRST    = 3'd1,
      EV_OPERATOR = 3'd2,
      EV_SECOND   = 3'd3,
      EV_RESULT   = 3'd4,
      EV_QUOTIENT = 3'd5,
      EV_CLEARED  = 3'd6,
      EV_DIVZERO  = 3'd7
   } event_type;

   // Stored operator
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Sequencer states of the top level
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_WAIT = 2'd2,
      ST_OUT  = 2'd3
   } state_type;

   // Command to the bit-serial multiply/divide unit
   typedef struct packed {
      logic start;
      logic is_div;
   } md_cmd_type;

   // Status back from the multiply/divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage

@@ rtl/kffc_muldiv.sv @@
// Bit-serial shift-add multiplier and restoring divider.
module kffc_muldiv #(
   parameter int NUM_WIDTH = kffc_pkg::NUM_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kffc_pkg::md_cmd_type     cmd,
   input  logic [NUM_WIDTH-1:0]     opa,
   input  logic [NUM_WIDTH-1:0]     opb,
   output kffc_pkg::md_stat_type    stat,
   output logic [NUM_WIDTH-1:0]     hi_out,   // product, or remainder
   output logic [NUM_WIDTH-1:0]     lo_out    // quotient
);

   localparam int CNT_W = $clog2(NUM_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 div_ff, div_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] hi_ff, hi_in;
   logic [NUM_WIDTH-1:0] lo_ff, lo_in;
   logic [NUM_WIDTH-1:0] b_ff, b_in;
   logic [NUM_WIDTH:0]   shifted;
   logic [NUM_WIDTH:0]   diff;

   // One step: add-and-shift for multiply, trial subtract for divide
   always_comb begin
      shifted = {hi_ff, lo_ff[NUM_WIDTH-1]};
      diff    = shifted - {1'b0, b_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      b_in    = b_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         cnt_in  = CNT_W'(NUM_WIDTH - 1);
         hi_in   = '0;
         lo_in   = cmd.is_div ? opa : opb;
         b_in    = cmd.is_div ? opb : opa;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!diff[NUM_WIDTH]) begin
               hi_in = diff[NUM_WIDTH-1:0];
               lo_in = {lo_ff[NUM_WIDTH-2:0], 1'b1};
            end else begin
               hi_in = shifted[NUM_WIDTH-1:0];
               lo_in = {lo_ff[NUM_WIDTH-2:0], 1'b0};
            end
         end else begin
            hi_in = hi_ff + (lo_ff[0] ? b_ff : '0);
            lo_in = {1'b0, lo_ff[NUM_WIDTH-1:1]};
            b_in  = {b_ff[NUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      b_ff   <= b_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign hi_out    = hi_ff;
   assign lo_out    = lo_ff;

endmodule

@@ rtl/keypad_four_function_calculator.sv @@
// Top level: key decoding, operand registers, sequencer and response register.
//
// Usage: one key press enters per transaction on the req_ channel (kind on
// req_tuser, digit value on req_tdata) and exactly one response leaves on
// the rsp_ channel (event code on rsp_tuser, shown value and remainder on
// rsp_tdata).
// Each accepted key passes through the execute and output states before its
// response is registered; equals with multiply or a nonzero divide also
// waits in the wait state while the bit-serial unit runs one bit per cycle.
// One key is worked on at a time; req_tready is high only while the
// sequencer is idle.
// The response sits in an output register, so the next key is accepted
// while an earlier response still waits; if the receiver stalls, a finished
// result is held internally until the output register frees up.
// Reset (synchronous, active high) clears both operands, selects add,
// returns to first-operand entry and drops rsp_tvalid. The clear key does
// the same to the calculator state and answers with a cleared event.
module keypad_four_function_calculator #(
   parameter int NUM_WIDTH = kffc_pkg::NUM_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] digit, [7:4] zero
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] shown_value, [63:32] remainder
   output logic [2:0]  rsp_tuser    // [2:0] event_res
);

   localparam int OW = kffc_pkg::OUT_WIDTH;

   kffc_pkg::state_type   state_ff, state_in;
   kffc_pkg::op_type      pend_ff;
   kffc_pkg::md_cmd_type  md_cmd;
   kffc_pkg::md_stat_type md_stat;
   kffc_pkg::event_type   res_ev_ff;
   logic [NUM_WIDTH-1:0]  first_ff;
   logic [NUM_WIDTH-1:0]  second_ff;
   logic                  phase_ff;
   logic [2:0]            key_ff;
   logic [3:0]            digit_ff;
   logic [OW-1:0]         res_val_ff;
   logic [OW-1:0]         res_rem_ff;
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_ev_ff;
   logic [OW-1:0]         rsp_val_ff;
   logic [OW-1:0]         rsp_rem_ff;
   logic [NUM_WIDTH-1:0]  md_hi;
   logic [NUM_WIDTH-1:0]  md_lo;
   logic [NUM_WIDTH-1:0]  acc_sel;
   logic [NUM_WIDTH-1:0]  acc_next;
   logic                  accept;
   logic                  need_md;
   logic                  out_free;
   logic                  load_rsp;

   // Multiply by ten and add the digit: acc*8 + acc*2 + digit
   always_comb begin
      acc_sel  = phase_ff ? second_ff : first_ff;
      acc_next = {acc_sel[NUM_WIDTH-4:0], 3'b000} + {acc_sel[NUM_WIDTH-2:0], 1'b0}
               + NUM_WIDTH'(digit_ff);
   end

   // Equals that needs the serial unit
   assign need_md = phase_ff && (key_ff == kffc_pkg::KEY_EQUALS)
                 && (pend_ff == kffc_pkg::OP_MUL
                     || (pend_ff == kffc_pkg::OP_DIV && second_ff != '0));

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kffc_pkg::ST_IDLE: if (req_tvalid) state_in = kffc_pkg::ST_EXEC;
         kffc_pkg::ST_EXEC: state_in = need_md ? kffc_pkg::ST_WAIT : kffc_pkg::ST_OUT;
         kffc_pkg::ST_WAIT: if (md_stat.done) state_in = kffc_pkg::ST_OUT;
         kffc_pkg::ST_OUT:  if (out_free) state_in = kffc_pkg::ST_IDLE;
         default:           state_in = kffc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      md_cmd.start  = 1'b0;
      md_cmd.is_div = (pend_ff == kffc_pkg::OP_DIV);
      load_rsp      = 1'b0;
      case (state_ff)
         kffc_pkg::ST_IDLE: req_tready   = 1'b1;
         kffc_pkg::ST_EXEC: md_cmd.start = need_md;
         kffc_pkg::ST_WAIT: ;
         kffc_pkg::ST_OUT:  load_rsp     = out_free;
         default:           ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kffc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Calculator state: updated when a key executes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         pend_ff   <= kffc_pkg::OP_ADD;
         phase_ff  <= 1'b0;
      end else if (state_ff == kffc_pkg::ST_EXEC) begin
         if (key_ff == kffc_pkg::KEY_CLEAR) begin
            first_ff  <= '0;
            second_ff <= '0;
            pend_ff   <= kffc_pkg::OP_ADD;
            phase_ff  <= 1'b0;
         end else if (key_ff == kffc_pkg::KEY_DIGIT) begin
            if (phase_ff) begin
               second_ff <= acc_next;
            end else begin
               first_ff <= acc_next;
            end
         end else if (!phase_ff
                      && key_ff inside {[kffc_pkg::KEY_ADD:kffc_pkg::KEY_DIV]}) begin
            pend_ff  <= kffc_pkg::op_type'(2'(key_ff - 3'd1));
            phase_ff <= 1'b1;
         end
      end
   end

   // Key capture and pending result
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff   <= req_tuser;
         digit_ff <= req_tdata[3:0];
      end
      if (state_ff == kffc_pkg::ST_EXEC) begin
         res_rem_ff <= '0;
         if (key_ff == kffc_pkg::KEY_CLEAR) begin
            res_ev_ff  <= kffc_pkg::EV_CLEARED;
            res_val_ff <= '0;
         end else if (key_ff == kffc_pkg::KEY_DIGIT) begin
            res_ev_ff  <= phase_ff ? kffc_pkg::EV_SECOND : kffc_pkg::EV_FIRST;
            res_val_ff <= OW'(acc_next);
         end else if (!phase_ff
                      && key_ff inside {[kffc_pkg::KEY_ADD:kffc_pkg::KEY_DIV]}) begin
            res_ev_ff  <= kffc_pkg::EV_OPERATOR;
            res_val_ff <= OW'(first_ff);
         end else if (phase_ff && key_ff == kffc_pkg::KEY_EQUALS) begin
            case (pend_ff)
               kffc_pkg::OP_ADD: begin
                  res_ev_ff  <= kffc_pkg::EV_RESULT;
                  res_val_ff <= OW'(first_ff + second_ff);
               end
               kffc_pkg::OP_SUB: begin
                  res_ev_ff  <= kffc_pkg::EV_RESULT;
                  res_val_ff <= OW'(first_ff - second_ff);
               end
               default: begin
                  // multiply and nonzero divide finish in the wait state
                  res_ev_ff  <= kffc_pkg::EV_DIVZERO;
                  res_val_ff <= '0;
               end
            endcase
         end else begin
            res_ev_ff  <= kffc_pkg::EV_IGNORED;
            res_val_ff <= '0;
         end
      end else if (state_ff == kffc_pkg::ST_WAIT && md_stat.done) begin
         if (pend_ff == kffc_pkg::OP_DIV) begin
            res_ev_ff  <= kffc_pkg::EV_QUOTIENT;
            res_val_ff <= OW'(md_lo);
            res_rem_ff <= OW'(md_hi);
         end else begin
            res_ev_ff  <= kffc_pkg::EV_RESULT;
            res_val_ff <= OW'(md_hi);
            res_rem_ff <= '0;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ev_ff  <= res_ev_ff;
         rsp_val_ff <= res_val_ff;
         rsp_rem_ff <= res_rem_ff;
      end
   end

   kffc_muldiv #(
      .NUM_WIDTH(NUM_WIDTH)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .opa   (first_ff),
      .opb   (second_ff),
      .stat  (md_stat),
      .hi_out(md_hi),
      .lo_out(md_lo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tdata  = {rsp_rem_ff, rsp_val_ff};

`ifndef NO_ASSERTIONS
   // The serial unit is started only from the execute state
   a_start_exec: assert property (@(posedge clock) disable iff (reset)
      md_cmd.start |-> state_ff == kffc_pkg::ST_EXEC)
      else $error("muldiv started outside execute");

   // Waiting for the serial unit only for multiply or divide
   a_wait_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == kffc_pkg::ST_WAIT
      |-> (pend_ff == kffc_pkg::OP_MUL || pend_ff == kffc_pkg::OP_DIV))
      else $error("wait state with add or subtract pending");

   // While waiting, the serial unit is running or just finished
   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == kffc_pkg::ST_WAIT |-> (md_stat.busy || md_stat.done))
      else $error("waiting on an idle muldiv unit");

   // A new response appears only after the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == kffc_pkg::ST_OUT))
      else $error("response raised outside output state");
`endif

endmodule
